FILE: design/fsp_pkg.sv
// Package for the FASTA stream parser: character codes, parse modes,
// result kinds and the result word type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int FIELD_BITS         = 32;
    localparam int BYTE_BITS          = 8;

    localparam logic [BYTE_BITS-1:0] CHAR_GT    = 8'h3E;
    localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_BITS-1:0] CHAR_VT    = 8'h0B;
    localparam logic [BYTE_BITS-1:0] CHAR_FF    = 8'h0C;
    localparam logic [BYTE_BITS-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [BYTE_BITS-1:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [BYTE_BITS-1:0] CASE_BIT   = 8'h20;

    typedef enum logic [1:0] {
        MODE_BEFORE = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_DRAIN  = 2'd2,
        MODE_SEQ    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        RES_NAME = 2'd0,
        RES_BASE = 2'd1,
        RES_END  = 2'd2
    } t_res_kind;

    typedef enum logic {
        IN_TEXT = 1'b0,
        IN_EOF  = 1'b1
    } t_in_kind;

    typedef struct packed {
        logic [FIELD_BITS-1:0] seq_len;
        logic [FIELD_BITS-1:0] rec_id;
        logic [BYTE_BITS-1:0]  out_byte;
        t_res_kind             kind;
    } t_result;

endpackage

`default_nettype wire

FILE: design/fasta_stream_parser.sv
// FASTA stream parser top level: byte-wise record parser with an output
// register and a skid stage. Depends on fsp_pkg.
//
// Usage:
//   Slave side takes one word per cycle while tready is high: tdata = text
//   byte, tuser = 1 marks end of file (tdata ignored). Master side gives
//   name bytes, uppercased sequence bases and record-end words with the
//   record id and base count. A word that causes no result (blanks, dropped
//   header tail, bytes before the first '>') is consumed silently.
// Output: each result is registered in the output register, or in the skid
//   stage while that register is held, before it shows on the master side.
// Throughput: one word per cycle while tready is high; the mode register and
//   the two counters update in the same cycle the word is accepted.
// Reset: parse mode returns to "before first header", counters clear and
//   both output stages empty.
// Stall: while the master side is stalled one more result is held in the
//   skid stage; with that stage full, tready on the slave side drops until
//   the receiver takes a word.
`timescale 1ns / 1ps
`default_nettype none

module fasta_stream_parser #(
    parameter int COUNT_BITS = fsp_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    input  wire logic        i_s_axis_tuser,   // [0] kind
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [71:0]      o_m_axis_tdata,   // [7:0] out_byte, [39:8] record_id,
                                               // [71:40] sequence_length
    output logic [1:0]       o_m_axis_tuser    // [1:0] result_kind
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    fsp_pkg::t_mode            r_mode, n_mode;
    logic                      r_name_started, n_name_started;
    logic [COUNT_BITS-1:0]     r_base, n_base;
    logic [COUNT_BITS-1:0]     r_rec, n_rec;

    logic                      r_out_valid, r_skid_valid;
    logic                      n_out_valid, n_skid_valid;
    fsp_pkg::t_result          r_out, r_skid;

    logic                      in_fire, out_fire;
    logic                      emit;
    fsp_pkg::t_result          res;
    logic [7:0]                b;
    logic                      is_blank, is_space;
    logic [COUNT_BITS-1:0]     base_inc, rec_inc;
    logic [fsp_pkg::FIELD_BITS-1:0] id_f, len_f;

    generate
        if (COUNT_BITS >= fsp_pkg::FIELD_BITS) begin : g_trunc
            assign id_f  = r_rec[fsp_pkg::FIELD_BITS-1:0];
            assign len_f = r_base[fsp_pkg::FIELD_BITS-1:0];
        end else begin : g_ext
            assign id_f  = {{(fsp_pkg::FIELD_BITS-COUNT_BITS){1'b0}}, r_rec};
            assign len_f = {{(fsp_pkg::FIELD_BITS-COUNT_BITS){1'b0}}, r_base};
        end
    endgenerate

    assign o_s_axis_tready = !r_skid_valid;
    assign in_fire  = i_s_axis_tvalid && !r_skid_valid;
    assign out_fire = r_out_valid && i_m_axis_tready;

    assign b        = i_s_axis_tdata;
    assign is_blank = (b == fsp_pkg::CHAR_SPACE) || (b == fsp_pkg::CHAR_TAB);
    assign is_space = (b == fsp_pkg::CHAR_SPACE) || (b == fsp_pkg::CHAR_TAB) ||
                      (b == fsp_pkg::CHAR_LF) || (b == fsp_pkg::CHAR_CR) ||
                      (b == fsp_pkg::CHAR_VT) || (b == fsp_pkg::CHAR_FF);
    assign base_inc = (r_base == COUNT_MAX) ? r_base : r_base + 1'b1;
    assign rec_inc  = (r_rec == COUNT_MAX) ? r_rec : r_rec + 1'b1;

    always_comb begin
        n_mode         = r_mode;
        n_name_started = r_name_started;
        n_base         = r_base;
        n_rec          = r_rec;
        emit           = 1'b0;
        res.kind       = fsp_pkg::RES_NAME;
        res.out_byte   = b;
        res.rec_id     = id_f;
        res.seq_len    = '0;
        if (fsp_pkg::t_in_kind'(i_s_axis_tuser) == fsp_pkg::IN_EOF) begin
            if (r_mode != fsp_pkg::MODE_BEFORE) begin
                emit         = 1'b1;
                res.kind     = fsp_pkg::RES_END;
                res.out_byte = '0;
                res.seq_len  = len_f;
            end
            n_mode         = fsp_pkg::MODE_BEFORE;
            n_name_started = 1'b0;
            n_base         = '0;
            n_rec          = '0;
        end else if (r_mode == fsp_pkg::MODE_DRAIN) begin
            if (b == fsp_pkg::CHAR_LF) begin
                n_mode = fsp_pkg::MODE_SEQ;
            end
        end else if (b == fsp_pkg::CHAR_GT) begin
            if (r_mode != fsp_pkg::MODE_BEFORE) begin
                emit         = 1'b1;
                res.kind     = fsp_pkg::RES_END;
                res.out_byte = '0;
                res.seq_len  = len_f;
                n_rec        = rec_inc;
            end
            n_base         = '0;
            n_name_started = 1'b0;
            n_mode         = fsp_pkg::MODE_HEADER;
        end else begin
            case (r_mode)
                fsp_pkg::MODE_HEADER: begin
                    if (b == fsp_pkg::CHAR_LF || b == fsp_pkg::CHAR_CR) begin
                        n_mode = fsp_pkg::MODE_SEQ;
                    end else if (is_blank) begin
                        if (r_name_started) begin
                            n_mode = fsp_pkg::MODE_DRAIN;
                        end
                    end else begin
                        n_name_started = 1'b1;
                        emit           = 1'b1;
                    end
                end
                fsp_pkg::MODE_SEQ: begin
                    if (!is_space) begin
                        emit     = 1'b1;
                        res.kind = fsp_pkg::RES_BASE;
                        n_base   = base_inc;
                        if (b >= fsp_pkg::CHAR_LOW_A && b <= fsp_pkg::CHAR_LOW_Z) begin
                            res.out_byte = b & ~fsp_pkg::CASE_BIT;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= fsp_pkg::MODE_BEFORE;
            r_name_started <= 1'b0;
            r_base         <= '0;
            r_rec          <= '0;
        end else if (in_fire) begin
            r_mode         <= n_mode;
            r_name_started <= n_name_started;
            r_base         <= n_base;
            r_rec          <= n_rec;
        end
    end

    // skid stays full until the output register is taken and the skid drains into it
    assign n_skid_valid = (r_skid_valid && !out_fire) ||
                          (in_fire && emit && r_out_valid && !out_fire);
    assign n_out_valid  = r_skid_valid || (r_out_valid && !out_fire) || (in_fire && emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire && r_skid_valid) begin
            r_out <= r_skid;
        end else if (in_fire && emit && (!r_out_valid || out_fire)) begin
            r_out <= res;
        end
        if (in_fire && emit && r_out_valid && !out_fire) begin
            r_skid <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.seq_len, r_out.rec_id, r_out.out_byte};
    assign o_m_axis_tuser  = r_out.kind;

endmodule

`default_nettype wire
